// File: rtl/pip_pkg.sv
// Shared types and constants of the point-in-polygon test unit.
`default_nettype none
package pip_pkg;

  localparam int COORD_W = 16;
  localparam int IDX_W   = 4;
  localparam int VCNT_W  = 5;

  localparam logic [VCNT_W-1:0] VCNT_RESET = 5'd3;
  localparam logic [VCNT_W-1:0] VCNT_MIN   = 5'd3;

  localparam logic REQ_VERTEX = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  typedef struct packed {
    logic                      req_type;
    logic [IDX_W-1:0]          vertex_index;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
  } pip_req_t;

  typedef struct packed {
    logic inside_res;
    logic on_boundary;
  } pip_res_t;

  typedef struct packed {
    logic rd_en;
    logic first;
    logic last;
  } pip_rd_ctl_t;

  typedef enum logic [1:0] {
    PIP_IDLE,
    PIP_READ,
    PIP_WAIT
  } pip_state_t;

endpackage
`default_nettype wire

// File: rtl/pip_vertex_ram.sv
// Vertex table: one write port, one registered read port.
`default_nettype none
module pip_vertex_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/pip_ctrl.sv
// Query sequencer: walks the vertex table one entry per cycle.
`default_nettype none
module pip_ctrl #(
  parameter int MAX_VERTICES = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            query_go,
  input  wire logic [pip_pkg::VCNT_W-1:0]      vcount,
  input  wire logic                            eu_done,
  output logic                                 busy,
  output pip_pkg::pip_rd_ctl_t                 rd_ctl,
  output logic [$clog2(MAX_VERTICES)-1:0]      rd_addr
);

  localparam int AW = $clog2(MAX_VERTICES);

  pip_pkg::pip_state_t state_r, state_nxt;
  logic [AW-1:0] rd_idx_r, rd_idx_nxt;
  logic [AW-1:0] last_r, last_nxt;
  logic [31:0]   n_sel;

  always_comb begin
    priority if (vcount < pip_pkg::VCNT_MIN) begin
      n_sel = 32'(pip_pkg::VCNT_MIN);
    end else if (32'(vcount) > 32'(MAX_VERTICES)) begin
      n_sel = 32'(MAX_VERTICES);
    end else begin
      n_sel = 32'(vcount);
    end
  end

  always_comb begin
    state_nxt  = state_r;
    rd_idx_nxt = rd_idx_r;
    last_nxt   = last_r;
    unique case (state_r)
      pip_pkg::PIP_IDLE: begin
        if (query_go) begin
          state_nxt  = pip_pkg::PIP_READ;
          rd_idx_nxt = '0;
          last_nxt   = AW'(n_sel - 32'd1);
        end
      end
      pip_pkg::PIP_READ: begin
        rd_idx_nxt = rd_idx_r + AW'(1);
        if (rd_idx_r == last_r) begin
          state_nxt = pip_pkg::PIP_WAIT;
        end
      end
      pip_pkg::PIP_WAIT: begin
        if (eu_done) begin
          state_nxt = pip_pkg::PIP_IDLE;
        end
      end
      default: state_nxt = pip_pkg::PIP_IDLE;
    endcase
  end

  always_comb begin
    busy         = 1'b1;
    rd_ctl.rd_en = 1'b0;
    rd_ctl.first = 1'b0;
    rd_ctl.last  = 1'b0;
    rd_addr      = rd_idx_r;
    unique case (state_r)
      pip_pkg::PIP_IDLE: begin
        busy = 1'b0;
      end
      pip_pkg::PIP_READ: begin
        rd_ctl.rd_en = 1'b1;
        rd_ctl.first = (rd_idx_r == '0);
        rd_ctl.last  = (rd_idx_r == last_r);
      end
      pip_pkg::PIP_WAIT: begin
        busy = 1'b1;
      end
      default: busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= pip_pkg::PIP_IDLE;
      rd_idx_r <= '0;
      last_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      rd_idx_r <= rd_idx_nxt;
      last_r   <= last_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/pip_edge_unit.sv
// Shared edge evaluator: on-edge and ray-crossing test, accumulated per query.
`default_nettype none
module pip_edge_unit #(
  parameter int CW = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 vld,
  input  wire logic                 last,
  input  wire logic signed [CW-1:0] ax,
  input  wire logic signed [CW-1:0] ay,
  input  wire logic signed [CW-1:0] bx,
  input  wire logic signed [CW-1:0] by,
  input  wire logic signed [CW-1:0] px,
  input  wire logic signed [CW-1:0] py,
  output logic                      done,
  output pip_pkg::pip_res_t         res
);

  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;

  logic s1_vld_r, s1_last_r, s2_vld_r, s2_last_r;
  logic signed [DW-1:0] dxb_r, dyb_r, dxp_r, dyp_r;
  logic s1_box_r, s1_a_ab_r, s1_b_ab_r;
  logic signed [PW-1:0] l_r, r_r;
  logic s2_box_r, s2_strad_r, s2_b_ab_r;
  logic on_acc_r, par_r;
  logic on_now, cross_now, box_nxt;

  assign box_nxt = (px >= ax || px >= bx) && (px <= ax || px <= bx) &&
                   (py >= ay || py >= by) && (py <= ay || py <= by);

  always_ff @(posedge clk) begin
    dxb_r     <= DW'(bx) - DW'(ax);
    dyb_r     <= DW'(by) - DW'(ay);
    dxp_r     <= DW'(px) - DW'(ax);
    dyp_r     <= DW'(py) - DW'(ay);
    s1_box_r  <= box_nxt;
    s1_a_ab_r <= (ay > py);
    s1_b_ab_r <= (by > py);
    l_r        <= PW'(dyb_r) * PW'(dxp_r);
    r_r        <= PW'(dyp_r) * PW'(dxb_r);
    s2_box_r   <= s1_box_r;
    s2_strad_r <= s1_a_ab_r != s1_b_ab_r;
    s2_b_ab_r  <= s1_b_ab_r;
  end

  assign on_now    = (l_r == r_r) && s2_box_r;
  assign cross_now = s2_strad_r && (s2_b_ab_r ? (r_r > l_r) : (r_r < l_r));

  assign done            = s2_vld_r && s2_last_r;
  assign res.on_boundary = on_acc_r || on_now;
  assign res.inside_res  = res.on_boundary || (par_r ^ cross_now);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s1_last_r <= 1'b0;
      s2_vld_r  <= 1'b0;
      s2_last_r <= 1'b0;
      on_acc_r  <= 1'b0;
      par_r     <= 1'b0;
    end else begin
      s1_vld_r  <= vld;
      s1_last_r <= vld && last;
      s2_vld_r  <= s1_vld_r;
      s2_last_r <= s1_last_r;
      if (done) begin
        on_acc_r <= 1'b0;
        par_r    <= 1'b0;
      end else if (s2_vld_r) begin
        on_acc_r <= on_acc_r || on_now;
        par_r    <= par_r ^ cross_now;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/point_in_polygon_test_unit.sv
// Top level of the point-in-polygon test unit.
//
// Input channel: in_req is transferred at a rising edge with start high and
// busy low. A vertex load (req_type 0) writes one table slot in that cycle and
// gives no result; busy stays low, so loads can follow back to back.
// A query (req_type 1) raises busy while the sequencer reads the vertex
// table through its single read port, one vertex per cycle, and feeds one
// edge per cycle into the shared two-stage edge evaluator.
// After the walk over the vertices in use (vertex_count clamped to 3..MAX_VERTICES)
// the result shows on out_res with out_valid high for one cycle, registered from
// the edge evaluator's done strobe; busy drops in that same cycle, so the next
// request can be taken at once.
// The receiver cannot stall: out_valid marks each result for one cycle only.
// Configuration: cfg_data (vertex_count) is written when cfg_valid and
// cfg_ready are high; cfg_ready is always high. Write it only while idle.
// Reset (rst_n low, synchronous) clears the sequencer, drops busy and
// out_valid, and sets vertex_count to 3. The vertex table is not cleared:
// every slot a query reads must be loaded first.
`default_nettype none
module point_in_polygon_test_unit #(
  parameter int MAX_VERTICES = 16,
  parameter int COORD_BITS   = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire pip_pkg::pip_req_t            in_req,
  output logic                              out_valid,
  output pip_pkg::pip_res_t                 out_res,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [pip_pkg::VCNT_W-1:0]   cfg_data
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = (COORD_BITS < pip_pkg::COORD_W) ? COORD_BITS : pip_pkg::COORD_W;
  localparam int VW = 2 * CW;

  logic [pip_pkg::VCNT_W-1:0] vcount_r;
  logic                       accept, query_go, wr_en;
  logic [31:0]                idx_ext;
  logic [AW-1:0]              rd_addr;
  logic [VW-1:0]              wdata, rdata;
  pip_pkg::pip_rd_ctl_t       rd_ctl, dv_r;
  logic                       close_r;
  logic [VW-1:0]              first_r, prev_r, b_vtx;
  logic signed [CW-1:0]       pt_x_r, pt_y_r;
  logic                       eu_vld, eu_done;
  pip_pkg::pip_res_t          eu_res;
  logic                       out_valid_r;
  pip_pkg::pip_res_t          out_res_r;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign query_go  = accept && (in_req.req_type == pip_pkg::REQ_QUERY);
  assign idx_ext   = 32'(in_req.vertex_index);
  assign wr_en     = accept && (in_req.req_type == pip_pkg::REQ_VERTEX) &&
                     (idx_ext < 32'(MAX_VERTICES));
  assign wdata     = {in_req.coord_x[CW-1:0], in_req.coord_y[CW-1:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= pip_pkg::VCNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      vcount_r <= cfg_data;
    end
  end

  pip_ctrl #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .query_go(query_go),
    .vcount  (vcount_r),
    .eu_done (eu_done),
    .busy    (busy),
    .rd_ctl  (rd_ctl),
    .rd_addr (rd_addr)
  );

  pip_vertex_ram #(
    .DEPTH(MAX_VERTICES),
    .WIDTH(VW)
  ) u_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(idx_ext[AW-1:0]),
    .wdata(wdata),
    .re   (rd_ctl.rd_en),
    .raddr(rd_addr),
    .rdata(rdata)
  );

  // Hold the query point and the first and previous vertices of the walk.
  always_ff @(posedge clk) begin
    if (query_go) begin
      pt_x_r <= in_req.coord_x[CW-1:0];
      pt_y_r <= in_req.coord_y[CW-1:0];
    end
    if (dv_r.rd_en) begin
      prev_r <= rdata;
      if (dv_r.first) begin
        first_r <= rdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r    <= '0;
      close_r <= 1'b0;
    end else begin
      dv_r    <= rd_ctl;
      close_r <= dv_r.rd_en && dv_r.last;
    end
  end

  assign eu_vld = (dv_r.rd_en && !dv_r.first) || close_r;
  assign b_vtx  = close_r ? first_r : rdata;

  pip_edge_unit #(
    .CW(CW)
  ) u_edge (
    .clk  (clk),
    .rst_n(rst_n),
    .vld  (eu_vld),
    .last (close_r),
    .ax   (prev_r[VW-1:CW]),
    .ay   (prev_r[CW-1:0]),
    .bx   (b_vtx[VW-1:CW]),
    .by   (b_vtx[CW-1:0]),
    .px   (pt_x_r),
    .py   (pt_y_r),
    .done (eu_done),
    .res  (eu_res)
  );

  always_ff @(posedge clk) begin
    if (eu_done) begin
      out_res_r <= eu_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= eu_done;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

`ifndef SYNTHESIS
  a_result_when_idle : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while a query is still running");

  a_load_no_result : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_req.req_type == pip_pkg::REQ_VERTEX) |=> !out_valid)
    else $error("vertex load produced a result");

  a_query_ends_in_result : assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(busy) && $past(rst_n)) |-> out_valid)
    else $error("query finished without a result");
`endif

endmodule
`default_nettype wire

// File: sim/polygon_scoreboard_pkg.sv
// Scoreboard for the point-in-polygon test unit: vertex table copy, answer prediction, checks.
package polygon_scoreboard_pkg;
  import pip_pkg::*;

  localparam int TABLE_DEPTH = 16;

  class polygon_scoreboard;
    logic signed [COORD_W-1:0] corner_x [TABLE_DEPTH];
    logic signed [COORD_W-1:0] corner_y [TABLE_DEPTH];
    logic [VCNT_W-1:0]         corner_count;
    pip_res_t                  expected_answers [$];
    int                        mismatches;

    function new();
      corner_count = VCNT_RESET;
      mismatches   = 0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        corner_x[i] = '0;
        corner_y[i] = '0;
      end
    endfunction

    function void set_count(logic [VCNT_W-1:0] value);
      corner_count = value;
    endfunction

    function int pending();
      return expected_answers.size();
    endfunction

    function void add_expected(pip_res_t answer);
      expected_answers = {expected_answers, answer};
    endfunction

    function pip_res_t classify_point(logic signed [COORD_W-1:0] px,
                                      logic signed [COORD_W-1:0] py);
      pip_res_t res;
      longint   x, y, ax, ay, bx, by, dy, lhs, rhs;
      int       n, j;
      bit       hit, odd;
      x   = px;
      y   = py;
      n   = int'(corner_count);
      hit = 1'b0;
      odd = 1'b0;
      if (n < int'(VCNT_MIN)) n = int'(VCNT_MIN);
      if (n > TABLE_DEPTH) n = TABLE_DEPTH;
      for (int i = 0; i < n; i++) begin
        j  = (i + 1 == n) ? 0 : i + 1;
        ax = corner_x[i];
        ay = corner_y[i];
        bx = corner_x[j];
        by = corner_y[j];
        if ((by - ay) * (x - ax) == (y - ay) * (bx - ax) &&
            x >= (ax < bx ? ax : bx) && x <= (ax > bx ? ax : bx) &&
            y >= (ay < by ? ay : by) && y <= (ay > by ? ay : by)) begin
          hit = 1'b1;
        end
        if ((ay > y) != (by > y)) begin
          dy  = by - ay;
          lhs = (bx - ax) * (y - ay);
          rhs = (x - ax) * dy;
          if (dy > 0 ? (lhs > rhs) : (lhs < rhs)) odd = ~odd;
        end
      end
      res.on_boundary = hit;
      res.inside_res  = hit | odd;
      return res;
    endfunction

    function void note_request(pip_req_t req);
      if (req.req_type == REQ_VERTEX) begin
        corner_x[req.vertex_index] = req.coord_x;
        corner_y[req.vertex_index] = req.coord_y;
      end else begin
        add_expected(classify_point(req.coord_x, req.coord_y));
      end
    endfunction

    function void check_answer(pip_res_t got);
      pip_res_t want;
      if (expected_answers.size() == 0) begin
        if (mismatches < 10)
          $display("mismatch: result with nothing expected, got inside=%0b edge=%0b",
                   got.inside_res, got.on_boundary);
        mismatches++;
        return;
      end
      want = expected_answers.pop_front();
      if (got.inside_res !== want.inside_res || got.on_boundary !== want.on_boundary) begin
        if (mismatches < 10)
          $display("mismatch: expected inside=%0b edge=%0b, got inside=%0b edge=%0b",
                   want.inside_res, want.on_boundary, got.inside_res, got.on_boundary);
        mismatches++;
      end
    endfunction
  endclass

endpackage

// File: sim/point_in_polygon_test_unit_tb.sv
// Testbench for point_in_polygon_test_unit: directed and random polygons, queries and config.
module point_in_polygon_test_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pip_pkg::*;
  import polygon_scoreboard_pkg::*;

  localparam int RESET_CYCLES   = 5;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 30;
  localparam int PHASE_ITEMS    = 206;
  localparam int NUM_PHASES     = 8;
  localparam int COUNT_PLAN [NUM_PHASES-1] = '{16, 0, 31, 7, 2, 17, 3};
  localparam int IDLE_PLAN [4]  = '{0, 71, 0, 26};
  localparam int EXTREMES [4]   = '{-32768, -1, 0, 32767};

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              start     = 1'b0;
  logic              cfg_valid = 1'b0;
  logic [VCNT_W-1:0] cfg_data  = '0;
  pip_req_t          in_req    = '0;
  logic              busy;
  logic              out_valid;
  logic              cfg_ready;
  pip_res_t          out_res;

  polygon_scoreboard sb;
  int                shape_x [TABLE_DEPTH];
  int                shape_y [TABLE_DEPTH];
  int                cur_count;
  int                sent_items;
  int                idle_pct;
  int                quiet_cycles = 0;

  point_in_polygon_test_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_answer(out_res);
      if (start && !busy) sb.note_request(in_req);
      if (cfg_valid && cfg_ready) sb.set_count(cfg_data);
      if (out_valid || (start && !busy) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("status: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic pip_req_t make_req(logic kind, int idx, int x, int y);
    pip_req_t r;
    r.req_type     = kind;
    r.vertex_index = idx[IDX_W-1:0];
    r.coord_x      = x[COORD_W-1:0];
    r.coord_y      = y[COORD_W-1:0];
    return r;
  endfunction

  function automatic int rand_coord();
    return int'($signed(16'($urandom)));
  endfunction

  function automatic int active_corners();
    if (cur_count < int'(VCNT_MIN)) return int'(VCNT_MIN);
    if (cur_count > TABLE_DEPTH) return TABLE_DEPTH;
    return cur_count;
  endfunction

  task automatic send_item(input pip_req_t r);
    if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    start  <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (busy);
    sent_items++;
  endtask

  task automatic load_vertex(input int idx, input int x, input int y);
    pip_req_t r;
    r = make_req(REQ_VERTEX, idx, x, y);
    shape_x[r.vertex_index] = int'(r.coord_x);
    shape_y[r.vertex_index] = int'(r.coord_y);
    send_item(r);
  endtask

  task automatic ask_point(input int x, input int y);
    send_item(make_req(REQ_QUERY, $urandom_range(15, 0), x, y));
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_vertex_count(input int value);
    cfg_valid <= 1'b1;
    cfg_data  <= value[VCNT_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_count = value;
  endtask

  task automatic run_polygon_set();
    int n, scale, a, b, dx, dy, g, r, j, qx, qy;
    bit full_span;
    n         = active_corners();
    scale     = $urandom_range(4095, 1);
    full_span = ($urandom_range(9, 0) >= 8);
    for (int i = 0; i < n; i++) begin
      if (i > 0 && $urandom_range(7, 0) == 0) begin
        qx = shape_x[i-1];
        qy = shape_y[i-1];
      end else if (full_span) begin
        qx = rand_coord();
        qy = rand_coord();
      end else begin
        qx = (int'($urandom_range(16, 0)) - 8) * scale;
        qy = (int'($urandom_range(16, 0)) - 8) * scale;
      end
      load_vertex(i, qx, qy);
      if ($urandom_range(9, 0) == 0) begin
        if ($urandom_range(1, 0) == 0) load_vertex($urandom_range(15, 0), rand_coord(),
                                                   rand_coord());
        else ask_point(rand_coord(), rand_coord());
      end
    end
    repeat ($urandom_range(10, 3)) begin
      a = $urandom_range(n - 1, 0);
      b = (a + 1 == n) ? 0 : a + 1;
      case ($urandom_range(5, 0))
        0: begin
          qx = shape_x[a];
          qy = shape_y[a];
        end
        1: begin
          dx = shape_x[b] - shape_x[a];
          dy = shape_y[b] - shape_y[a];
          g  = dx < 0 ? -dx : dx;
          r  = dy < 0 ? -dy : dy;
          while (r != 0) begin
            j = g % r;
            g = r;
            r = j;
          end
          j  = (g == 0) ? 0 : $urandom_range(g, 0);
          qx = shape_x[a] + ((g == 0) ? 0 : dx / g * j);
          qy = shape_y[a] + ((g == 0) ? 0 : dy / g * j);
        end
        2: begin
          if (full_span) begin
            qx = rand_coord();
            qy = rand_coord();
          end else begin
            qx = (int'($urandom_range(16, 0)) - 8) * scale + int'($urandom_range(2, 0)) - 1;
            qy = (int'($urandom_range(16, 0)) - 8) * scale + int'($urandom_range(2, 0)) - 1;
          end
        end
        3: begin
          qx = full_span ? rand_coord() : (int'($urandom_range(16, 0)) - 8) * scale;
          qy = shape_y[a];
        end
        4: begin
          qx = rand_coord();
          qy = rand_coord();
        end
        default: begin
          qx = EXTREMES[$urandom_range(3, 0)];
          qy = EXTREMES[$urandom_range(3, 0)];
        end
      endcase
      ask_point(qx, qy);
    end
  endtask

  initial begin
    int next_count;
    sb         = new();
    cur_count  = int'(VCNT_RESET);
    idle_pct   = 0;
    sent_items = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    load_vertex(0, -32768, -32768);
    load_vertex(1, 32767, -32768);
    load_vertex(2, -32768, 32767);
    for (int i = 3; i < TABLE_DEPTH; i++) load_vertex(i, i * 4369 - 32768, 32767 - i * 4369);
    ask_point(-32768, -32768);
    ask_point(0, -32768);
    ask_point(-1, 0);
    ask_point(0, 0);
    ask_point(-100, -100);
    ask_point(32767, 32767);
    ask_point(-32768, 0);
    ask_point(100, 32767);

    for (int p = 0; p < NUM_PHASES; p++) begin
      next_count = (p < NUM_PHASES - 1) ? COUNT_PLAN[p] : $urandom_range(31, 0);
      drain();
      write_vertex_count(next_count);
      idle_pct   = IDLE_PLAN[p % 4];
      sent_items = 0;
      while (sent_items < PHASE_ITEMS) run_polygon_set();
    end

    drain();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: point_in_polygon_test_unit.f
rtl/pip_pkg.sv
rtl/pip_vertex_ram.sv
rtl/pip_ctrl.sv
rtl/pip_edge_unit.sv
rtl/point_in_polygon_test_unit.sv
sim/polygon_scoreboard_pkg.sv
sim/point_in_polygon_test_unit_tb.sv
